### rtl/core/dnd_pkg.sv
// Shared types and constants for the DNS name decompressor.
package dnd_pkg;

    // Request opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_BAD_PTR   = 3'd2;
    localparam logic [2:0] ST_LABEL_LEN = 3'd3;
    localparam logic [2:0] ST_NAME_LEN  = 3'd4;

    // Label encoding
    localparam logic [1:0] PTR_TAG   = 2'b11;
    localparam logic [7:0] MAX_LABEL = 8'd63;
    localparam logic [7:0] DOT_CHAR  = 8'h2e;

    // Name buffer geometry: 8 characters per word
    localparam int NAME_WORDS = 32;
    localparam int NAME_AW    = 5;
    localparam int CHUNK_BITS = 64;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_PTR,
        S_COPY,
        S_DOT,
        S_FLUSH,
        S_E_RD,
        S_E_OUT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [NAME_AW-1:0]    addr;
        logic [CHUNK_BITS-1:0] data;
    } t_name_wr;

endpackage

### rtl/core/dnd_pkt_mem.sv
// Packet byte store: one write port, one registered read port.
module dnd_pkt_mem #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/dnd_name_mem.sv
// Decoded name buffer: 32 words of 8 characters, registered read.
module dnd_name_mem (
    input  logic                          i_clk,
    input  dnd_pkg::t_name_wr             i_wr,
    input  logic [dnd_pkg::NAME_AW-1:0]   i_raddr,
    output logic [dnd_pkg::CHUNK_BITS-1:0] o_rdata
);

    logic [dnd_pkg::CHUNK_BITS-1:0] r_mem [dnd_pkg::NAME_WORDS];
    logic [dnd_pkg::CHUNK_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/dns_name_decompressor.sv
// Top level of the DNS name decompressor: sequencer, cursor unit and result register.
//
// Loads write one packet byte per cycle while no decode is in progress. A decode walks
// the packet store through its single read port under a small sequencer: it reads each
// length byte, copies each label character, appends the dot after each label, reads both
// bytes of each compression pointer and the ending zero byte, flushes the last partial
// word, then reads the name buffer and sends result beats of up to 8 characters each,
// holding each beat while the result side stalls; an error sends a single error beat
// after the failing byte.
// The input is stalled while a decode is in progress; the final result beat sits
// in an output register so the next request is taken while it waits.
module dns_name_decompressor #(
    parameter int PACKET_BYTES   = 4096,
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic [11:0] i_position,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_name_chunk,
    output logic [3:0]  o_chunk_count,
    output logic        o_last,
    output logic [2:0]  o_status,
    output logic [7:0]  o_name_length,
    output logic [12:0] o_next_position
);

    localparam int AW = $clog2(PACKET_BYTES);

    dnd_pkg::t_state r_state, n_state;

    logic [12:0] r_plen, n_plen;
    logic [12:0] r_cur, n_cur;
    logic [11:0] r_run, n_run;
    logic [12:0] r_resume, n_resume;
    logic        r_followed, n_followed;
    logic [7:0]  r_len, n_len;
    logic [63:0] r_word, n_word;
    logic [5:0]  r_cnt, n_cnt;
    logic [5:0]  r_hi, n_hi;
    logic [2:0]  r_err, n_err;
    logic [4:0]  r_k, n_k;

    // result register
    logic        r_out_valid;
    logic [63:0] r_chunk;
    logic [3:0]  r_count;
    logic        r_last;
    logic [2:0]  r_stat;
    logic [7:0]  r_nlen;
    logic [12:0] r_next;

    logic        out_load;
    logic [63:0] ld_chunk;
    logic [3:0]  ld_count;
    logic        ld_last;
    logic [2:0]  ld_stat;
    logic [7:0]  ld_nlen;
    logic [12:0] ld_next;

    logic        accept;
    logic        out_free;
    logic        pkt_we;
    logic [7:0]  pkt_rdata;
    logic [63:0] name_rdata;
    dnd_pkg::t_name_wr name_wr;

    // cursor unit values
    logic [7:0]  b;
    logic        cur_past;
    logic [13:0] label_end;
    logic [8:0]  name_sum;
    logic [13:0] ptr_off;
    logic [7:0]  ch;
    logic [63:0] word_ins;
    logic [7:0]  rem;
    logic [7:0]  len_m1;
    logic        fin;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign pkt_we   = accept && (i_opcode == dnd_pkg::OP_LOAD)
                      && (32'(i_position) < PACKET_BYTES);

    dnd_pkt_mem #(
        .DEPTH (PACKET_BYTES)
    ) u_pkt_mem (
        .i_clk   (i_clk),
        .i_we    (pkt_we),
        .i_waddr (AW'(i_position)),
        .i_wdata (i_byte_value),
        .i_raddr (AW'(n_cur)),
        .o_rdata (pkt_rdata)
    );

    dnd_name_mem u_name_mem (
        .i_clk   (i_clk),
        .i_wr    (name_wr),
        .i_raddr (r_k),
        .o_rdata (name_rdata)
    );

    // read data always holds the byte at r_cur
    assign b         = pkt_rdata;
    assign cur_past  = (r_cur >= r_plen);
    assign label_end = 14'(r_cur) + 14'(b) + 14'd1;
    assign name_sum  = 9'(r_len) + 9'(b) + 9'd1;
    assign ptr_off   = {r_hi, b};
    assign ch        = (r_state == dnd_pkg::S_DOT) ? dnd_pkg::DOT_CHAR : b;

    // drop the character into its byte lane
    always_comb begin
        word_ins = r_word;
        for (int i = 0; i < 8; i++) begin
            if (r_len[2:0] == 3'(i)) begin
                word_ins[8*i +: 8] = ch;
            end
        end
    end

    // chunk bookkeeping for result beats
    assign rem    = r_len - {r_k, 3'b000};
    assign len_m1 = r_len - 8'd1;
    assign fin    = (r_len == 8'd0) || (r_k == len_m1[7:3]);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dnd_pkg::S_IDLE;
            r_plen  <= '0;
        end else begin
            r_state <= n_state;
            r_plen  <= n_plen;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_run      <= n_run;
        r_resume   <= n_resume;
        r_followed <= n_followed;
        r_len      <= n_len;
        r_word     <= n_word;
        r_cnt      <= n_cnt;
        r_hi       <= n_hi;
        r_err      <= n_err;
        r_k        <= n_k;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_plen     = r_plen;
        n_cur      = r_cur;
        n_run      = r_run;
        n_resume   = r_resume;
        n_followed = r_followed;
        n_len      = r_len;
        n_word     = r_word;
        n_cnt      = r_cnt;
        n_hi       = r_hi;
        n_err      = r_err;
        n_k        = r_k;
        name_wr    = '0;
        out_load   = 1'b0;
        ld_chunk   = '0;
        ld_count   = '0;
        ld_last    = 1'b1;
        ld_stat    = r_err;
        ld_nlen    = '0;
        ld_next    = '0;
        o_in_stall = (r_state != dnd_pkg::S_IDLE);

        unique case (r_state) inside
            dnd_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_opcode == dnd_pkg::OP_LOAD) begin
                        if (pkt_we && i_last_byte) begin
                            n_plen = 13'(i_position) + 13'd1;
                        end
                    end else begin
                        n_cur      = 13'(i_position);
                        n_run      = i_position;
                        n_followed = 1'b0;
                        n_len      = '0;
                        n_word     = '0;
                        n_state    = dnd_pkg::S_HEAD;
                    end
                end
            end

            // length byte or first pointer byte
            dnd_pkg::S_HEAD: begin
                if (cur_past) begin
                    n_err   = dnd_pkg::ST_TRUNCATED;
                    n_state = dnd_pkg::S_ERR;
                end else if (b[7:6] == dnd_pkg::PTR_TAG) begin
                    n_hi    = b[5:0];
                    n_cur   = r_cur + 13'd1;
                    n_state = dnd_pkg::S_PTR;
                end else if (b > dnd_pkg::MAX_LABEL) begin
                    n_err   = dnd_pkg::ST_LABEL_LEN;
                    n_state = dnd_pkg::S_ERR;
                end else if (b == 8'd0) begin
                    n_cur   = r_cur + 13'd1;
                    n_state = dnd_pkg::S_FLUSH;
                end else if (name_sum > 9'(MAX_NAME_BYTES)) begin
                    n_err   = dnd_pkg::ST_NAME_LEN;
                    n_state = dnd_pkg::S_ERR;
                end else if (label_end > 14'(r_plen)) begin
                    n_err   = dnd_pkg::ST_TRUNCATED;
                    n_state = dnd_pkg::S_ERR;
                end else begin
                    n_cnt   = b[5:0];
                    n_cur   = r_cur + 13'd1;
                    n_state = dnd_pkg::S_COPY;
                end
            end

            // second pointer byte; target must lie below the current run
            dnd_pkg::S_PTR: begin
                if (cur_past) begin
                    n_err   = dnd_pkg::ST_TRUNCATED;
                    n_state = dnd_pkg::S_ERR;
                end else if (ptr_off >= 14'(r_run)) begin
                    n_err   = dnd_pkg::ST_BAD_PTR;
                    n_state = dnd_pkg::S_ERR;
                end else begin
                    if (!r_followed) begin
                        n_resume   = r_cur + 13'd1;
                        n_followed = 1'b1;
                    end
                    n_cur   = 13'(ptr_off);
                    n_run   = 12'(ptr_off);
                    n_state = dnd_pkg::S_HEAD;
                end
            end

            // label text and trailing dot share the append path
            dnd_pkg::S_COPY, dnd_pkg::S_DOT: begin
                n_len = r_len + 8'd1;
                if (r_len[2:0] == 3'd7) begin
                    name_wr.we   = 1'b1;
                    name_wr.addr = r_len[7:3];
                    name_wr.data = word_ins;
                    n_word       = '0;
                end else begin
                    n_word = word_ins;
                end
                if (r_state == dnd_pkg::S_COPY) begin
                    n_cur = r_cur + 13'd1;
                    n_cnt = r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        n_state = dnd_pkg::S_DOT;
                    end
                end else begin
                    n_state = dnd_pkg::S_HEAD;
                end
            end

            // store the partial last word
            dnd_pkg::S_FLUSH: begin
                if (r_len[2:0] != 3'd0) begin
                    name_wr.we   = 1'b1;
                    name_wr.addr = r_len[7:3];
                    name_wr.data = r_word;
                end
                n_k     = '0;
                n_state = dnd_pkg::S_E_RD;
            end

            dnd_pkg::S_E_RD: begin
                n_state = dnd_pkg::S_E_OUT;
            end

            dnd_pkg::S_E_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    ld_count = (rem > 8'd8) ? 4'd8 : rem[3:0];
                    ld_chunk = (ld_count == 4'd0) ? '0 : name_rdata;
                    ld_last  = fin;
                    ld_stat  = dnd_pkg::ST_OK;
                    if (fin) begin
                        ld_nlen = r_len;
                        ld_next = r_followed ? r_resume : r_cur;
                        n_state = dnd_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + 5'd1;
                        n_state = dnd_pkg::S_E_RD;
                    end
                end
            end

            dnd_pkg::S_ERR: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = dnd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = dnd_pkg::S_IDLE;
            end
        endcase
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_chunk <= ld_chunk;
            r_count <= ld_count;
            r_last  <= ld_last;
            r_stat  <= ld_stat;
            r_nlen  <= ld_nlen;
            r_next  <= ld_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_name_chunk    = r_chunk;
    assign o_chunk_count   = r_count;
    assign o_last          = r_last;
    assign o_status        = r_stat;
    assign o_name_length   = r_nlen;
    assign o_next_position = r_next;

endmodule

### rtl/core/dnd_checker.sv
// Port-level checks for the DNS name decompressor, bound to the top level.
module dnd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_name_chunk,
    input logic [3:0]  o_chunk_count,
    input logic        o_last,
    input logic [2:0]  o_status,
    input logic [7:0]  o_name_length,
    input logic [12:0] o_next_position
);

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its chunk and count
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_name_chunk) && $stable(o_chunk_count))
        else $error("stalled result payload changed");

    // beats before the last carry a full chunk and no summary
    a_mid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == dnd_pkg::ST_OK && o_name_length == 8'd0
        && o_next_position == 13'd0 && o_chunk_count == 4'd8)
        else $error("non-final beat carries summary or short chunk");

    // an error beat is alone and empty
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != dnd_pkg::ST_OK |-> o_last && o_chunk_count == 4'd0
        && o_name_chunk == 64'd0 && o_name_length == 8'd0)
        else $error("error beat not empty");

    // the final chunk count agrees with the name length
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && o_status == dnd_pkg::ST_OK && o_name_length[2:0] != 3'd0
        |-> o_chunk_count == {1'b0, o_name_length[2:0]})
        else $error("final chunk count disagrees with name length");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (.*);

### sim/tb_dns_name_decompressor.sv
// Self-checking testbench for the DNS name decompressor: directed and random packets.
module tb_dns_name_decompressor;

    localparam int PKT_BYTES    = 4096;
    localparam int NAME_MAX     = 255;
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_DECODES = 100;
    // start offsets decoded in the hand-built packet (see the layout in the stimulus)
    localparam int DIRECTED_STARTS [21] = '{0, 4, 12, 17, 24, 26, 27, 29, 31, 33, 38,
                                            40, 41, 42, 107, 171, 363, 367, 368, 369, 370};

    typedef struct packed {
        logic        op;
        logic [7:0]  val;
        logic [11:0] pos;
        logic        last;
    } t_dns_req;

    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  count;
        logic        last;
        logic [2:0]  status;
        logic [7:0]  length;
        logic [12:0] next;
    } t_name_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_opcode = dnd_pkg::OP_LOAD;
    logic [7:0]  i_byte_value = 8'd0;
    logic [11:0] i_position = 12'd0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_name_chunk;
    logic [3:0]  o_chunk_count;
    logic        o_last;
    logic [2:0]  o_status;
    logic [7:0]  o_name_length;
    logic [12:0] o_next_position;

    // mirror of the block state
    logic [7:0]  pkt_mem [PKT_BYTES];
    logic [12:0] pkt_len;

    t_dns_req    pending_reqs [$];
    t_name_beat  expected_beats [$];
    logic [7:0]  image [$];
    int          heads [$];
    int          marks [$];
    int          filled_upto = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          reqs_sent = 0;
    int          beats_seen = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    dns_name_decompressor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_byte_value    (i_byte_value),
        .i_position      (i_position),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_name_chunk    (o_name_chunk),
        .o_chunk_count   (o_chunk_count),
        .o_last          (o_last),
        .o_status        (o_status),
        .o_name_length   (o_name_length),
        .o_next_position (o_next_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk labels and pointers from start, queue the chunk beats or the error beat
    function automatic void decode_name(input int start);
        logic [7:0]  text [256];
        logic [7:0]  b;
        logic [63:0] word;
        logic [2:0]  verdict;
        int          cur, run_start, resume, len, limit, off, beats, cnt;
        bit          followed, done;
        limit = (pkt_len > PKT_BYTES) ? PKT_BYTES : int'(pkt_len);
        cur = start;
        run_start = start;
        resume = 0;
        len = 0;
        followed = 1'b0;
        done = 1'b0;
        verdict = dnd_pkg::ST_OK;
        while (!done) begin
            if (cur >= limit) begin
                verdict = dnd_pkg::ST_TRUNCATED;
                done = 1'b1;
            end else begin
                b = pkt_mem[cur];
                cur++;
                if (b[7:6] == dnd_pkg::PTR_TAG) begin
                    if (cur >= limit) begin
                        verdict = dnd_pkg::ST_TRUNCATED;
                        done = 1'b1;
                    end else begin
                        off = int'({b[5:0], pkt_mem[cur]});
                        cur++;
                        // only strictly backwards jumps are legal
                        if (off >= run_start) begin
                            verdict = dnd_pkg::ST_BAD_PTR;
                            done = 1'b1;
                        end else begin
                            if (!followed) begin
                                resume = cur;
                                followed = 1'b1;
                            end
                            cur = off;
                            run_start = off;
                        end
                    end
                end else if (b > dnd_pkg::MAX_LABEL) begin
                    verdict = dnd_pkg::ST_LABEL_LEN;
                    done = 1'b1;
                end else if (b == 8'd0) begin
                    done = 1'b1;
                end else if (len + b + 1 > NAME_MAX) begin
                    verdict = dnd_pkg::ST_NAME_LEN;
                    done = 1'b1;
                end else if (cur + b > limit) begin
                    verdict = dnd_pkg::ST_TRUNCATED;
                    done = 1'b1;
                end else begin
                    for (int k = 0; k < b; k++) text[len + k] = pkt_mem[cur + k];
                    text[len + b] = dnd_pkg::DOT_CHAR;
                    len += b + 1;
                    cur += b;
                end
            end
        end

        if (verdict != dnd_pkg::ST_OK) begin
            expected_beats.push_back({64'd0, 4'd0, 1'b1, verdict, 8'd0, 13'd0});
        end else begin
            beats = (len + 7) / 8;
            if (beats == 0) beats = 1;
            for (int w = 0; w < beats; w++) begin
                word = '0;
                for (int j = 0; j < 8; j++)
                    if (8 * w + j < len) word[8 * j +: 8] = text[8 * w + j];
                cnt = (len - 8 * w > 8) ? 8 : len - 8 * w;
                if (w == beats - 1)
                    expected_beats.push_back({word, 4'(cnt), 1'b1, dnd_pkg::ST_OK, 8'(len),
                                              13'(followed ? resume : cur)});
                else
                    expected_beats.push_back({word, 4'(cnt), 1'b0, dnd_pkg::ST_OK, 8'd0,
                                              13'd0});
            end
        end
    endfunction

    function automatic void predict_request(input t_dns_req req);
        if (req.op == dnd_pkg::OP_LOAD) begin
            pkt_mem[req.pos] = req.val;
            if (req.last) pkt_len = 13'(req.pos) + 13'd1;
        end else begin
            decode_name(int'(req.pos));
        end
    endfunction

    // Packet image builders
    function automatic void put_label(input int n);
        image.push_back(8'(n));
        repeat (n) image.push_back(8'($urandom));
    endfunction

    function automatic void put_ptr(input int off);
        image.push_back({dnd_pkg::PTR_TAG, 6'(off >> 8)});
        image.push_back(8'(off));
    endfunction

    function automatic void queue_image();
        for (int i = 0; i < image.size(); i++)
            pending_reqs.push_back({dnd_pkg::OP_LOAD, image[i], 12'(i),
                                    1'(i == image.size() - 1)});
        if (image.size() > filled_upto) filled_upto = image.size();
    endfunction

    function automatic void queue_load(input logic [11:0] pos, input logic [7:0] val,
                                       input logic last);
        pending_reqs.push_back({dnd_pkg::OP_LOAD, val, pos, last});
    endfunction

    function automatic void queue_decode(input int pos);
        pending_reqs.push_back({dnd_pkg::OP_DECODE, 8'($urandom), 12'(pos), 1'($urandom)});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", field, got, want));
    endtask

    // Request driver: one beat per handshake, random gap before each
    always @(posedge i_clk) begin
        t_dns_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
            pkt_len = 13'd0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid)
                predict_request({i_opcode, i_byte_value, i_position, i_last_byte});
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                nxt = pending_reqs.pop_front();
                i_opcode     <= nxt.op;
                i_byte_value <= nxt.val;
                i_position   <= nxt.pos;
                i_last_byte  <= nxt.last;
                i_in_valid   <= 1'b1;
                gap_left = tx_burst ? 0 : $urandom_range(0, 3);
                reqs_sent++;
                if (reqs_sent % 16 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each beat, then stall for a random count
    always @(posedge i_clk) begin
        t_name_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat, chunk %h status %0d",
                                              o_name_chunk, o_status));
                end else begin
                    want = expected_beats.pop_front();
                    check_field("name_chunk", o_name_chunk, want.chunk);
                    check_field("chunk_count", 64'(o_chunk_count), 64'(want.count));
                    check_field("last", 64'(o_last), 64'(want.last));
                    check_field("status", 64'(o_status), 64'(want.status));
                    check_field("name_length", 64'(o_name_length), 64'(want.length));
                    check_field("next_position", 64'(o_next_position), 64'(want.next));
                end
                beats_seen++;
                if (beats_seen % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
                stall_left = rx_burst ? 0 : $urandom_range(0, 3);
            end else if (stall_left == 0 && !rx_burst && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus and end of test
    initial begin
        int  nn, nl, first, prior, spot, ndec, pick, decodes_left;
        bit  big;

        // nothing loaded yet: packet length is zero
        queue_decode(0);

        // Hand-built packet, offsets in comments
        put_label(3); put_label(7); put_label(3); image.push_back(8'h00); // 0: plain name
        put_label(4); put_ptr(4);                       // 17: label + pointer
        put_ptr(17);                                    // 24: pointer chain
        image.push_back(8'h00);                         // 26: root name
        put_ptr(27);                                    // 27: points at itself
        put_ptr(14'h3fff);                              // 29: far forward
        put_ptr(40);                                    // 31: forward in packet
        put_label(2); put_ptr(35);                      // 33: jump inside own run
        put_ptr(33);                                    // 38: back, then bad jump
        image.push_back(8'h40);                         // 40: reserved type, low end
        image.push_back(8'hbf);                         // 41: reserved type, high end
        put_label(63); image.push_back(8'h00);          // 42: longest label
        put_label(63); put_label(63); put_label(63);    // 107: longest legal name
        put_label(62); image.push_back(8'h00);
        put_label(1); put_ptr(107);                     // 363: two bytes too long
        image.push_back(8'd5);                          // 367: text runs off the end
        image.push_back(8'd1);                          // 368: length byte off the end
        image.push_back(8'hc1);                         // 369: half a pointer
        queue_image();
        queue_load(12'hfff, 8'hff, 1'b0);
        foreach (DIRECTED_STARTS[i]) queue_decode(DIRECTED_STARTS[i]);
        queue_decode(4095);

        // Random packets: mostly well-formed names with compression, some damage
        decodes_left = RANDOM_DECODES;
        while (decodes_left > 0) begin
            image.delete();
            heads.delete();
            marks.delete();
            nn = $urandom_range(2, 5);
            for (int n = 0; n < nn; n++) begin
                first = image.size();
                prior = marks.size();
                heads.push_back(first);
                marks.push_back(first);
                big = ($urandom_range(0, 7) == 0);
                nl = big ? $urandom_range(3, 5) : $urandom_range(0, 3);
                for (int j = 0; j < nl; j++) begin
                    if (j > 0) marks.push_back(image.size());
                    put_label(big ? $urandom_range(40, 63) : $urandom_range(1, 12));
                end
                if (prior > 0 && $urandom_range(0, 1) == 1)
                    put_ptr(marks[$urandom_range(0, prior - 1)]);
                else
                    image.push_back(8'h00);
            end

            // damage one spot, or cut the tail, in about a third of the packets
            if ($urandom_range(0, 2) == 0) begin
                spot = $urandom_range(0, image.size() - 1);
                case ($urandom_range(0, 3))
                    0: image[spot] = 8'($urandom);
                    1: image[spot] = 8'($urandom_range(64, 191));
                    2: image[spot] = {dnd_pkg::PTR_TAG, 6'($urandom)};
                    default: repeat ($urandom_range(1, 4))
                        if (image.size() > 1) void'(image.pop_back());
                endcase
            end
            queue_image();

            // stray writes; a moved end stays inside bytes already written
            repeat ($urandom_range(0, 2)) queue_load(12'($urandom), 8'($urandom), 1'b0);
            if ($urandom_range(0, 3) == 0)
                queue_load(12'($urandom_range(0, filled_upto - 1)), 8'($urandom), 1'b1);

            ndec = $urandom_range(3, 7);
            for (int d = 0; d < ndec; d++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    queue_decode(heads[$urandom_range(0, heads.size() - 1)]);
                else if (pick < 8)
                    queue_decode(marks[$urandom_range(0, marks.size() - 1)]);
                else if (pick < 9)
                    queue_decode($urandom_range(0, image.size() + 1));
                else
                    queue_decode($urandom_range(0, 4095));
            end
            decodes_left -= ndec;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_in_valid || expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
